// File: hdl/sis_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sis_pkg: shared types and helpers for the sorted interval set
// Holds the bound-pair type, item kind codes and the double ordering key.
// ---------------------------------------------------------------------------
package sis_pkg;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] up;
    } t_pair;

    // Map a double bit pattern onto an unsigned key with the same order.
    function automatic logic [63:0] order_key(input logic [63:0] bits);
        logic [63:0] b;
        b = (bits == SIGN_BIT) ? 64'd0 : bits;
        if (b[63]) begin
            return ~b;
        end
        return b | SIGN_BIT;
    endfunction

endpackage : sis_pkg
`default_nettype wire

// File: hdl/sis_item_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sis_item_if: input channel of the sorted interval set
// Valid/ready handshake carrying one insert or lookup item.
// ---------------------------------------------------------------------------
interface sis_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  dimension;
    logic [63:0] lower_bound;
    logic [63:0] upper_bound;

    modport source (output valid, output kind, output dimension,
                    output lower_bound, output upper_bound, input ready);
    modport sink   (input valid, input kind, input dimension,
                    input lower_bound, input upper_bound, output ready);
endinterface : sis_item_if
`default_nettype wire

// File: hdl/sis_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sis_result_if: result channel of the sorted interval set
// Valid/ready handshake carrying one result item per input item.
// ---------------------------------------------------------------------------
interface sis_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] position;
    logic       inserted;
    logic       table_full;
    logic [6:0] entry_count;

    modport source (output valid, output found, output position, output inserted,
                    output table_full, output entry_count, input ready);
    modport sink   (input valid, input found, input position, input inserted,
                    input table_full, input entry_count, output ready);
endinterface : sis_result_if
`default_nettype wire

// File: hdl/sis_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sis_store: bound-pair table memory
// One write port and one registered read port over all dimension tables.
// ---------------------------------------------------------------------------
module sis_store
    import sis_pkg::*;
#(
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_pair         i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_pair              o_rd_data
);

    t_pair r_mem [DEPTH];
    t_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule : sis_store
`default_nettype wire

// File: hdl/sorted_interval_set.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_interval_set: per-dimension sorted tables of unique bound pairs
// Binary search on a shared pair comparator over one memory read port, then
// an entry-by-entry shift to open the slot for an insert.
// ---------------------------------------------------------------------------
// Lookup: binary search over a table of n entries, one compare per cycle
// against the registered read. An insert then shifts the entries above the
// position up by one, or only writes the new slot when appending.
// One item at a time; ready is high only while idle, so the next item is taken
// only once the result has registered. A waiting result does not block input.
// Reset clears the fill counts and control state; memory contents are kept.
// ---------------------------------------------------------------------------
module sorted_interval_set
    import sis_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_BOUNDS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sis_item_if.sink      i_item,
    sis_result_if.source  o_result
);

    localparam int DEPTH = MAX_DIMS * MAX_BOUNDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BOUNDS + 1);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [CW-1:0] FULL_N = CW'(MAX_BOUNDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SRCH,
        S_CHK,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state         r_state;
    logic           r_kind;
    logic           r_dim_ok;
    logic [DW-1:0]  r_dim;
    t_pair          r_key;
    logic [CW-1:0]  r_n;
    logic [CW-1:0]  r_left;
    logic [CW-1:0]  r_right;
    logic [CW-1:0]  r_mid;
    logic [CW-1:0]  r_sh;
    logic [CW-1:0]  r_wpos;
    logic           r_pend;
    logic           r_chk;
    logic           r_found;
    logic           r_ins;
    logic           r_full;
    logic [CW-1:0]  r_fill [MAX_DIMS];

    logic           r_ov;
    logic           r_o_found;
    logic [5:0]     r_o_pos;
    logic           r_o_ins;
    logic           r_o_full;
    logic [6:0]     r_o_cnt;

    logic           wr_en;
    logic [CW-1:0]  wr_idx;
    t_pair          wr_data;
    logic [CW-1:0]  rd_idx;
    t_pair          rd_data;

    logic           less;
    logic           eq;
    logic [CW-1:0]  n_left;
    logic [CW-1:0]  n_right;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  n_mid;
    logic [CW-1:0]  fill_cur;
    logic           out_free;
    logic [DW+1:0]  dim_ext;
    logic [CW+5:0]  pos_ext;
    logic [CW+6:0]  cnt_ext;

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] d,
                                             input logic [CW-1:0] idx);
        return AW'(d) * AW'(MAX_BOUNDS) + AW'(idx);
    endfunction

    sis_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (f_addr(r_dim, wr_idx)),
        .i_wr_data (wr_data),
        .i_rd_addr (f_addr(r_dim, rd_idx)),
        .o_rd_data (rd_data)
    );

    // Shared pair comparator against the entry read last cycle.
    assign less     = {rd_data.lo, rd_data.up} < {r_key.lo, r_key.up};
    assign eq       = (rd_data == r_key);
    assign n_left   = less ? (r_mid + CW'(1)) : r_left;
    assign n_right  = less ? r_right : r_mid;
    assign mid_sum  = {1'b0, n_left} + {1'b0, n_right};
    assign n_mid    = mid_sum[CW:1];
    assign fill_cur = r_dim_ok ? r_fill[r_dim] : '0;
    assign out_free = !r_ov || o_result.ready;
    assign dim_ext  = (DW + 2)'(i_item.dimension);
    assign pos_ext  = (CW + 6)'(r_left);
    assign cnt_ext  = (CW + 7)'(r_n);

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_wpos;
        wr_data = rd_data;
        rd_idx  = r_mid;
        unique case (r_state)
            S_START: rd_idx = fill_cur >> 1;
            S_SRCH:  rd_idx = (n_left < n_right) ? n_mid : n_left;
            S_SHIFT: begin
                rd_idx = r_sh - CW'(1);
                if (r_pend) begin
                    wr_en = 1'b1;
                end else if (r_sh == r_left) begin
                    // drop the new pair into the opened slot
                    wr_en   = 1'b1;
                    wr_idx  = r_left;
                    wr_data = r_key;
                end
            end
            default: rd_idx = r_mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_fill[d] <= '0;
            end
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_kind   <= i_item.kind;
                        r_dim_ok <= 5'(i_item.dimension) < 5'(MAX_DIMS);
                        r_dim    <= dim_ext[DW-1:0];
                        r_key.lo <= order_key(i_item.lower_bound);
                        r_key.up <= order_key(i_item.upper_bound);
                        r_state  <= S_START;
                    end
                end
                S_START: begin
                    r_found <= 1'b0;
                    r_ins   <= 1'b0;
                    r_full  <= 1'b0;
                    r_left  <= '0;
                    r_n     <= fill_cur;
                    r_right <= fill_cur;
                    r_mid   <= fill_cur >> 1;
                    r_chk   <= 1'b0;
                    r_pend  <= 1'b0;
                    if (!r_dim_ok) begin
                        r_state <= S_DONE;
                    end else if (fill_cur == '0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_left  <= n_left;
                    r_right <= n_right;
                    if (n_left < n_right) begin
                        r_mid <= n_mid;
                    end else begin
                        r_chk   <= n_left < r_n;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_chk && eq) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_kind == KIND_INSERT) begin
                        if (r_n == FULL_N) begin
                            r_full  <= 1'b1;
                            r_left  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_sh    <= r_n;
                            r_pend  <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_left  <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (r_sh > r_left) begin
                        // move entry sh-1 up to sh; its data lands next cycle
                        r_pend <= 1'b1;
                        r_wpos <= r_sh;
                        r_sh   <= r_sh - CW'(1);
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                    end else begin
                        r_n           <= r_n + CW'(1);
                        r_fill[r_dim] <= r_n + CW'(1);
                        r_ins         <= 1'b1;
                        r_state       <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_found <= r_found;
                        r_o_pos   <= pos_ext[5:0];
                        r_o_ins   <= r_ins;
                        r_o_full  <= r_full;
                        r_o_cnt   <= cnt_ext[6:0];
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_ov;
    assign o_result.found       = r_o_found;
    assign o_result.position    = r_o_pos;
    assign o_result.inserted    = r_o_ins;
    assign o_result.table_full  = r_o_full;
    assign o_result.entry_count = r_o_cnt;

endmodule : sorted_interval_set
`default_nettype wire

// File: hdl/sis_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sis_checker: port-level assertions for the sorted interval set
// Watches the result channel for consistent flags, a held stalled item and no valid after reset.
// ---------------------------------------------------------------------------
module sis_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_found,
    input wire logic [5:0] i_position,
    input wire logic       i_inserted,
    input wire logic       i_table_full,
    input wire logic [6:0] i_entry_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
            && $stable(i_position) && $stable(i_inserted)
            && $stable(i_table_full) && $stable(i_entry_count))
        else $error("stalled result item changed");

    a_found_xor_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_found && i_inserted))
        else $error("item both found and inserted");

    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> !i_found && !i_inserted
            && i_position == 6'd0 && i_entry_count != 7'd0)
        else $error("table full result with other flags");

endmodule : sis_checker

bind sorted_interval_set sis_checker u_sis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_found       (o_result.found),
    .i_position    (o_result.position),
    .i_inserted    (o_result.inserted),
    .i_table_full  (o_result.table_full),
    .i_entry_count (o_result.entry_count)
);
`default_nettype wire

// File: sim/sorted_interval_set_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_interval_set_tb: self-checking bench for the sorted interval set
// Drives insert and lookup items through the item channel. A local table
// model keeps per-dimension ordered pair keys and predicts each result,
// which is checked in order against the result channel. Covers signed-zero
// folding, ties on the lower bound, a full table, back-pressure and random
// traffic.
// ---------------------------------------------------------------------------
module sorted_interval_set_tb;
    import sis_pkg::*;

    localparam int DIMS         = 4;
    localparam int BOUNDS       = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [63:0] NOTABLE_BOUNDS [10] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
        64'h7FFF_FFFF_FFFF_FFFF
    };

    typedef struct packed {
        logic       found;
        logic [5:0] position;
        logic       inserted;
        logic       table_full;
        logic [6:0] entry_count;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sis_item_if   item_ch ();
    sis_result_if result_ch ();

    sorted_interval_set #(
        .MAX_DIMS   (DIMS),
        .MAX_BOUNDS (BOUNDS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Table model: ordered keys per dimension
    t_pair       bound_pairs [DIMS][BOUNDS];
    int unsigned pair_count  [DIMS];
    t_outcome    pending_outcomes [$];

    int error_count   = 0;
    int idle_pct      = 0;
    int hold_off_left = 0;
    int stall_left    = 0;
    int cycle_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] ordering_key(input logic [63:0] bits);
        logic [63:0] b;
        b = (bits == SIGN_BIT) ? 64'd0 : bits;
        if (b[63]) begin
            return ~b;
        end
        return b | SIGN_BIT;
    endfunction

    // Recover a bit pattern from a key; zero comes back as either sign.
    function automatic logic [63:0] key_to_bits(input logic [63:0] key);
        if (key == SIGN_BIT) begin
            return ($urandom_range(0, 1) != 0) ? SIGN_BIT : 64'd0;
        end
        if (key[63]) begin
            return key & ~SIGN_BIT;
        end
        return ~key;
    endfunction

    function automatic t_outcome search_and_insert(input logic kind, input logic [1:0] dim,
                                                   input logic [63:0] lo_bits,
                                                   input logic [63:0] up_bits);
        t_pair       probe;
        t_outcome    res;
        int unsigned n;
        int unsigned left;
        int unsigned right;
        int unsigned mid;
        probe.lo = ordering_key(lo_bits);
        probe.up = ordering_key(up_bits);
        res = '0;
        n = pair_count[dim];
        left = 0;
        right = n;
        // Find the first entry not below the probe
        while (left < right) begin
            mid = left + (right - left) / 2;
            if (bound_pairs[dim][mid] < probe) begin
                left = mid + 1;
            end else begin
                right = mid;
            end
        end
        if (left < n && bound_pairs[dim][left] == probe) begin
            res.found = 1'b1;
            res.position = left[5:0];
        end else if (kind == KIND_INSERT) begin
            if (n >= BOUNDS) begin
                res.table_full = 1'b1;
            end else begin
                for (int i = n; i > left; i--) begin
                    bound_pairs[dim][i] = bound_pairs[dim][i-1];
                end
                bound_pairs[dim][left] = probe;
                n++;
                pair_count[dim] = n;
                res.inserted = 1'b1;
                res.position = left[5:0];
            end
        end
        res.entry_count = n[6:0];
        return res;
    endfunction

    function automatic logic [63:0] random_bound();
        case ($urandom_range(0, 3))
            0: return NOTABLE_BOUNDS[$urandom_range(0, 9)];
            // narrow set of values so lower bounds tie often
            1: return {1'($urandom_range(0, 1)), 11'h400, 20'($urandom_range(0, 7)), 32'd0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [1:0] dim,
                             input logic [63:0] lo, input logic [63:0] up);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.dimension   <= dim;
        item_ch.lower_bound <= lo;
        item_ch.upper_bound <= up;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
    endtask

    task automatic send_random_item();
        logic [1:0]  dim;
        logic        kind;
        logic [63:0] lo;
        logic [63:0] up;
        int unsigned n;
        int unsigned r;
        t_pair       p;
        dim = 2'($urandom_range(0, DIMS - 1));
        n = pair_count[dim];
        r = $urandom_range(0, 99);
        if (n > 0 && r < 60) begin
            // pair already in the table: hit or duplicate insert
            p = bound_pairs[dim][$urandom_range(0, n - 1)];
            lo = key_to_bits(p.lo);
            up = key_to_bits(p.up);
            kind = (r < 35) ? KIND_LOOKUP : KIND_INSERT;
        end else begin
            lo = random_bound();
            up = random_bound();
            kind = ($urandom_range(0, 99) < 30) ? KIND_LOOKUP : KIND_INSERT;
        end
        send_item(kind, dim, lo, up);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_basic_pairs();
        idle_pct = 10;
        send_item(KIND_LOOKUP, 2'd0, 64'd0, 64'd0);
        send_item(KIND_INSERT, 2'd0, 64'd0, 64'd0);
        // negative zero folds onto positive zero
        send_item(KIND_LOOKUP, 2'd0, SIGN_BIT, SIGN_BIT);
        send_item(KIND_INSERT, 2'd0, SIGN_BIT, 64'd0);
        send_item(KIND_INSERT, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 2'd0, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
        send_item(KIND_INSERT, 2'd0, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_item(KIND_INSERT, 2'd0, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_item(KIND_INSERT, 2'd0, 64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_item(KIND_LOOKUP, 2'd0, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_item(KIND_LOOKUP, 2'd0, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_item(KIND_INSERT, 2'd0, SIGN_BIT | 64'd1, 64'd0);
        send_item(KIND_LOOKUP, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int d = 1; d < DIMS; d++) begin
            send_item(KIND_LOOKUP, 2'(d), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
            send_item(KIND_INSERT, 2'(d), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
            send_item(KIND_LOOKUP, 2'(d), SIGN_BIT, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        hold_off_left = 500;
        repeat (30) send_random_item();
        wait_drained();
    endtask

    task automatic test_random_mix(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            send_random_item();
        end
        wait_drained();
    endtask

    task automatic test_full_table();
        int unsigned room;
        t_pair       p;
        idle_pct = 10;
        room = BOUNDS - pair_count[3];
        repeat (room) send_item(KIND_INSERT, 2'd3, {$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();
        send_item(KIND_INSERT, 2'd3, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(KIND_INSERT, 2'd3, random_bound(), random_bound());
        p = bound_pairs[3][0];
        send_item(KIND_INSERT, 2'd3, key_to_bits(p.lo), key_to_bits(p.up));
        p = bound_pairs[3][pair_count[3] - 1];
        send_item(KIND_LOOKUP, 2'd3, key_to_bits(p.lo), key_to_bits(p.up));
        send_item(KIND_LOOKUP, 2'd3, {$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();
    endtask

    task automatic test_streaming(input int count);
        idle_pct = 0;
        repeat (count) send_random_item();
        wait_drained();
    endtask

    // Receiver: long hold-off on request, otherwise random stall bursts
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
            pending_outcomes.push_back(search_and_insert(item_ch.kind, item_ch.dimension,
                                                         item_ch.lower_bound,
                                                         item_ch.upper_bound));
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            got = '{result_ch.found, result_ch.position, result_ch.inserted,
                    result_ch.table_full, result_ch.entry_count};
            if (pending_outcomes.size() == 0) begin
                if (error_count < REPORT_LIMIT) begin
                    $display("unexpected result: found=%0d pos=%0d ins=%0d full=%0d count=%0d",
                             got.found, got.position, got.inserted, got.table_full,
                             got.entry_count);
                end
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.found !== want.found || got.position !== want.position ||
                    got.inserted !== want.inserted || got.table_full !== want.table_full ||
                    got.entry_count !== want.entry_count) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("mismatch: expected found=%0d pos=%0d ins=%0d full=%0d count=%0d",
                                 want.found, want.position, want.inserted, want.table_full,
                                 want.entry_count);
                        $display("          actual   found=%0d pos=%0d ins=%0d full=%0d count=%0d",
                                 got.found, got.position, got.inserted, got.table_full,
                                 got.entry_count);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        for (int d = 0; d < DIMS; d++) begin
            pair_count[d] = 0;
        end
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_INSERT;
        item_ch.dimension   <= 2'd0;
        item_ch.lower_bound <= 64'd0;
        item_ch.upper_bound <= 64'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_pairs();
        test_backpressure();
        test_random_mix(1050);
        test_full_table();
        test_streaming(180);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : sorted_interval_set_tb
`default_nettype wire
